// ----- hdl/azss_pkg.sv -----
package azss_pkg;

    localparam int VOLT_WIDTH = 24;
    localparam int CFG_WIDTH  = 24;
    localparam int CFG_IDX_W  = 3;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_R1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_R1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_R2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_R2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_R3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_R3 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_THR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_SLP  = 3'd7;

    localparam int SLOPE_W = 20;
    localparam int KNEE_W  = 23;
    localparam int RECIP_W = 25;

    localparam logic [SLOPE_W-1:0]   SLOPE_R1_RST  = 20'd64986;
    localparam logic [CFG_WIDTH-1:0] OFFSET_R1_RST = 24'd20312;
    localparam logic [SLOPE_W-1:0]   SLOPE_R2_RST  = 20'd66911;
    localparam logic [CFG_WIDTH-1:0] OFFSET_R2_RST = 24'd8590;
    localparam logic [SLOPE_W-1:0]   SLOPE_R3_RST  = 20'd66898;
    localparam logic [CFG_WIDTH-1:0] OFFSET_R3_RST = 24'd517;
    localparam logic [KNEE_W-1:0]    KNEE_THR_RST  = 23'd5213433;
    localparam logic [SLOPE_W-1:0]   KNEE_SLP_RST  = 20'd536739;

    localparam int ONE_VOLT   = 1048576;
    localparam int TENTH_VOLT = 104857;
    localparam int MILLI_VOLT = 1048;
    localparam int KNEE_BASE  = 5190451;

    localparam logic [2:0] ZERO_SWITCH = 3'd4;

    localparam logic [1:0] RANGE_ONE   = 2'd1;
    localparam logic [1:0] RANGE_TWO   = 2'd2;
    localparam logic [1:0] RANGE_THREE = 2'd3;

    // Sequence phases
    localparam logic [2:0] PH_SELECT = 3'd1;
    localparam logic [2:0] PH_RANGE  = 3'd2;
    localparam logic [2:0] PH_WAIT   = 3'd3;
    localparam logic [2:0] PH_ZERO   = 3'd4;
    localparam logic [2:0] PH_SETTLE = 3'd5;

    typedef struct packed {
        logic [2:0]                   channel;
        logic signed [VOLT_WIDTH-1:0] sample;
    } acq_req_t;

    typedef struct packed {
        logic [2:0]                   input_select;
        logic [1:0]                   gain_range;
        logic signed [VOLT_WIDTH-1:0] weight_voltage;
        logic                         value_updated;
    } rpt_req_t;

    typedef struct packed {
        logic latch_in;
        logic set_select;
        logic mul_ir;
        logic range_eval;
        logic diff;
        logic mul_cal;
        logic cal_finish;
        logic emit;
        logic updated;
    } azss_cmd_t;

    typedef struct packed {
        logic range_change;
    } azss_sts_t;

    // Reciprocal gain in units of 2^-24: x1, x4.48, x45
    function automatic logic [RECIP_W-1:0] recip_gain(input logic [1:0] idx);
        logic [RECIP_W-1:0] r;
        case (idx)
            2'd0:    r = 25'd16777216;
            2'd1:    r = 25'd3744914;
            2'd2:    r = 25'd372827;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/azss_ctrl.sv -----
module azss_ctrl
    import azss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       acq_valid,
    output logic       acq_ready,
    input  logic [2:0] channel,
    output logic       rpt_valid,
    input  logic       rpt_ready,
    input  azss_sts_t  sts,
    output azss_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_IR    = 3'd2;
    localparam logic [2:0] S_MULC  = 3'd3;
    localparam logic [2:0] S_CAL   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] last_ch_reg, last_ch_next;
    logic [2:0] work_ph_reg, work_ph_next;
    logic       upd_reg, upd_next;
    logic       rpt_valid_reg, rpt_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SELECT;
            last_ch_reg   <= 3'd0;
            work_ph_reg   <= PH_SELECT;
            upd_reg       <= 1'b0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            last_ch_reg   <= last_ch_next;
            work_ph_reg   <= work_ph_next;
            upd_reg       <= upd_next;
            rpt_valid_reg <= rpt_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        last_ch_next   = last_ch_reg;
        work_ph_next   = work_ph_reg;
        upd_next       = upd_reg;
        rpt_valid_next = rpt_valid_reg;
        cmd            = '0;
        cmd.updated    = upd_reg;
        acq_ready      = 1'b0;

        if (rpt_valid_reg && rpt_ready)
        begin
            rpt_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                acq_ready = 1'b1;
                if (acq_valid)
                begin
                    cmd.latch_in = 1'b1;
                    // a channel change restarts the sequence
                    work_ph_next = (channel != last_ch_reg) ? PH_SELECT : phase_reg;
                    last_ch_next = channel;
                    upd_next     = 1'b0;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                case (work_ph_reg)
                    PH_SELECT:
                    begin
                        cmd.set_select = 1'b1;
                        phase_next     = PH_RANGE;
                        state_next     = S_EMIT;
                    end
                    PH_RANGE, PH_ZERO:
                    begin
                        cmd.mul_ir = 1'b1;
                        state_next = S_IR;
                    end
                    PH_WAIT:
                    begin
                        phase_next = PH_ZERO;
                        state_next = S_EMIT;
                    end
                    PH_SETTLE:
                    begin
                        phase_next = PH_RANGE;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        phase_next = PH_SELECT;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_IR:
            begin
                if (work_ph_reg == PH_RANGE)
                begin
                    cmd.range_eval = 1'b1;
                    phase_next     = sts.range_change ? PH_SETTLE : PH_WAIT;
                    state_next     = S_EMIT;
                end
                else
                begin
                    cmd.diff   = 1'b1;
                    state_next = S_MULC;
                end
            end
            S_MULC:
            begin
                cmd.mul_cal = 1'b1;
                state_next  = S_CAL;
            end
            S_CAL:
            begin
                cmd.cal_finish = 1'b1;
                upd_next       = 1'b1;
                phase_next     = PH_SETTLE;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!rpt_valid_reg || rpt_ready)
                begin
                    cmd.emit       = 1'b1;
                    rpt_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rpt_valid = rpt_valid_reg;

endmodule

// ----- hdl/azss_datapath.sv -----
module azss_datapath
    import azss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  acq_req_t             acq,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    input  azss_cmd_t            cmd,
    output azss_sts_t            sts,
    output rpt_req_t             rpt
);

    localparam int W   = VOLT_WIDTH;
    localparam int AW  = W + 1;
    localparam int CW  = (AW + 1 > KNEE_W + 1) ? AW + 1 : KNEE_W + 1;
    localparam int PW  = AW + RECIP_W + 1;

    logic [SLOPE_W-1:0]   slope_r1_reg, slope_r2_reg, slope_r3_reg, knee_slp_reg;
    logic [CFG_WIDTH-1:0] offset_r1_reg, offset_r2_reg, offset_r3_reg;
    logic [KNEE_W-1:0]    knee_thr_reg;

    logic signed [W-1:0]  sample_reg;
    logic [2:0]           sel_reg;
    logic [1:0]           range_reg, range_next;
    logic signed [W-1:0]  raw_reg, raw_next;
    logic signed [W-1:0]  cal_reg, cal_next;
    logic [2:0]           sw_reg, sw_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] d_reg;
    logic                 knee_reg;
    rpt_req_t             rpt_reg;

    logic [1:0]           ridx;
    logic signed [AW-1:0] mul_a;
    logic [RECIP_W-1:0]   mul_b;
    logic signed [PW-1:0] ir_sum;
    logic signed [W-1:0]  ir;
    logic signed [CW-1:0] ir_ext;
    logic [1:0]           nr;
    logic signed [AW-1:0] d_next;
    logic signed [CW-1:0] d_ext;
    logic signed [CW-1:0] dk_ext;
    logic signed [PW-1:0] cal_q;
    logic signed [PW-1:0] cal_term;
    logic signed [PW-1:0] cal_sum;
    logic signed [W-1:0]  cal_sat;
    logic [SLOPE_W-1:0]   slope_sel;
    logic [CFG_WIDTH-1:0] offset_sel;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_r1_reg  <= SLOPE_R1_RST;
            offset_r1_reg <= OFFSET_R1_RST;
            slope_r2_reg  <= SLOPE_R2_RST;
            offset_r2_reg <= OFFSET_R2_RST;
            slope_r3_reg  <= SLOPE_R3_RST;
            offset_r3_reg <= OFFSET_R3_RST;
            knee_thr_reg  <= KNEE_THR_RST;
            knee_slp_reg  <= KNEE_SLP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SLOPE_R1:  slope_r1_reg  <= cfg_wdata[SLOPE_W-1:0];
                CFG_OFFSET_R1: offset_r1_reg <= cfg_wdata;
                CFG_SLOPE_R2:  slope_r2_reg  <= cfg_wdata[SLOPE_W-1:0];
                CFG_OFFSET_R2: offset_r2_reg <= cfg_wdata;
                CFG_SLOPE_R3:  slope_r3_reg  <= cfg_wdata[SLOPE_W-1:0];
                CFG_OFFSET_R3: offset_r3_reg <= cfg_wdata;
                CFG_KNEE_THR:  knee_thr_reg  <= cfg_wdata[KNEE_W-1:0];
                CFG_KNEE_SLP:  knee_slp_reg  <= cfg_wdata[SLOPE_W-1:0];
                default:       knee_slp_reg  <= knee_slp_reg;
            endcase
        end
    end

    assign ridx = (range_reg == 2'd0) ? 2'd0 : range_reg - 2'd1;

    always_comb
    begin
        case (ridx)
            2'd1:    slope_sel = slope_r2_reg;
            2'd2:    slope_sel = slope_r3_reg;
            default: slope_sel = slope_r1_reg;
        endcase
        case (ridx)
            2'd1:    offset_sel = offset_r2_reg;
            2'd2:    offset_sel = offset_r3_reg;
            default: offset_sel = offset_r1_reg;
        endcase
    end

    // Shared multiplier operands
    assign dk_ext = CW'(d_reg) - $signed({{(CW-KNEE_W){1'b0}}, knee_thr_reg});

    always_comb
    begin
        if (cmd.mul_ir)
        begin
            mul_a = AW'(sample_reg);
            mul_b = recip_gain(ridx);
        end
        else if (knee_reg)
        begin
            mul_a = dk_ext[AW-1:0];
            mul_b = RECIP_W'(knee_slp_reg);
        end
        else
        begin
            mul_a = d_reg;
            mul_b = RECIP_W'(slope_sel);
        end
    end

    // Input-referred value, rounded
    assign ir_sum = prod_reg + (PW'(1) <<< 23);
    assign ir     = W'(ir_sum >>> 24);
    assign ir_ext = CW'(ir);

    always_comb
    begin
        if (ir_ext > CW'(ONE_VOLT))
        begin
            nr = RANGE_ONE;
        end
        else if (ir_ext > CW'(TENTH_VOLT))
        begin
            nr = RANGE_TWO;
        end
        else
        begin
            nr = RANGE_THREE;
        end
    end

    assign sts.range_change = (nr != range_reg);

    assign d_next = AW'(raw_reg) - AW'(ir);
    assign d_ext  = CW'(d_next);

    // Calibration result, saturated
    assign cal_q    = (prod_reg + (PW'(1) <<< 15)) >>> 16;
    assign cal_term = knee_reg ? PW'(KNEE_BASE) : PW'($signed(offset_sel));
    assign cal_sum  = cal_q + cal_term;

    always_comb
    begin
        if (cal_sum > PW'((64'sd1 <<< (W - 1)) - 1))
        begin
            cal_sat = {1'b0, {(W-1){1'b1}}};
        end
        else if (cal_sum < -(PW'(1) <<< (W - 1)))
        begin
            cal_sat = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            cal_sat = cal_sum[W-1:0];
        end
    end

    always_comb
    begin
        range_next = range_reg;
        raw_next   = raw_reg;
        cal_next   = cal_reg;
        sw_next    = sw_reg;
        if (cmd.set_select)
        begin
            sw_next    = sel_reg;
            range_next = RANGE_ONE;
        end
        if (cmd.range_eval)
        begin
            if (sts.range_change)
            begin
                range_next = nr;
            end
            else
            begin
                raw_next = ir;
                sw_next  = ZERO_SWITCH;
            end
        end
        if (cmd.cal_finish)
        begin
            // drop small range-three readings to zero
            if (ridx == 2'd2 && !knee_reg && cal_sat <= W'(MILLI_VOLT))
            begin
                cal_next = '0;
            end
            else
            begin
                cal_next = cal_sat;
            end
            sw_next = sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= RANGE_ONE;
            raw_reg   <= '0;
            cal_reg   <= '0;
            sw_reg    <= 3'd0;
        end
        else
        begin
            range_reg <= range_next;
            raw_reg   <= raw_next;
            cal_reg   <= cal_next;
            sw_reg    <= sw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            sample_reg <= acq.sample;
            sel_reg    <= (acq.channel >= ZERO_SWITCH) ? ZERO_SWITCH : acq.channel;
        end
        if (cmd.mul_ir || cmd.mul_cal)
        begin
            prod_reg <= PW'(mul_a) * PW'($signed({1'b0, mul_b}));
        end
        if (cmd.diff)
        begin
            d_reg    <= d_next;
            knee_reg <= (ridx == 2'd0) && (d_ext >= $signed(CW'(knee_thr_reg)));
        end
        if (cmd.emit)
        begin
            rpt_reg.input_select   <= sw_reg;
            rpt_reg.gain_range     <= range_reg;
            rpt_reg.weight_voltage <= cal_reg;
            rpt_reg.value_updated  <= cmd.updated;
        end
    end

    assign rpt = rpt_reg;

endmodule

// ----- hdl/autorange_zeroing_scale_sequencer_core.sv -----
// Auto-ranging, zeroing scale front-end sequencer.
// Input channel acq (valid/ready): one ADC sample with the requested channel
// per request. Output channel rpt (valid/ready): one report per request with
// the switch position, gain range, latest calibrated voltage and an update flag.
// Config port: cfg_wr_en, cfg_index, cfg_wdata write one of eight calibration
// registers; write only while no request is in flight.
// One request is worked at a time. After acceptance, the select, wait and settle
// phases go from the start state straight to the report; the range phase adds a
// pass through the shared multiplier (gain reciprocal) and the zeroing phase
// runs two passes through it (gain reciprocal, then calibration slope). Once
// the report is loaded the sequencer returns to idle and takes the next request.
// The report sits in an output register: acq_ready returns while a report
// waits, but if rpt_ready stays low the next report holds in the sequencer
// until the register frees.
// Reset restores the default calibration, phase one, range one, zero readings
// and an empty output register.
module autorange_zeroing_scale_sequencer_core
    import azss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 acq_valid,
    output logic                 acq_ready,
    input  acq_req_t             acq,
    output logic                 rpt_valid,
    input  logic                 rpt_ready,
    output rpt_req_t             rpt,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata
);

    azss_cmd_t cmd;
    azss_sts_t sts;

    azss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acq_valid (acq_valid),
        .acq_ready (acq_ready),
        .channel   (acq.channel),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    azss_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .acq       (acq),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .rpt       (rpt)
    );

endmodule

// ----- hdl/azss_checker.sv -----
module azss_checker
    import azss_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 acq_valid,
    input logic                 acq_ready,
    input acq_req_t             acq,
    input logic                 rpt_valid,
    input logic                 rpt_ready,
    input rpt_req_t             rpt,
    input logic                 cfg_wr_en,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_WIDTH-1:0] cfg_wdata
);

    // Stalled report holds
    a_rpt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt))
        else $error("report changed while stalled");

    // One request in flight at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        acq_valid && acq_ready |=> !acq_ready)
        else $error("request accepted while another is in flight");

    a_range_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> rpt.gain_range != 2'd0)
        else $error("gain range zero reported");

    a_select_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> rpt.input_select <= ZERO_SWITCH)
        else $error("switch position out of range");

    // An updated report never rises straight after a request is accepted
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        acq_valid && acq_ready |=> !(rpt_valid && $rose(rpt_valid) && rpt.value_updated))
        else $error("report appeared too early");

endmodule

bind autorange_zeroing_scale_sequencer_core azss_checker u_azss_checker (.*);
